>>> hw/rtl/insertion_sorter_top_defines.svh
// Assertion macros for the insertion sorter.
// The macros expect signals named clock and reset in the scope that uses them.
`ifndef INSERTION_SORTER_TOP_DEFINES_SVH
`define INSERTION_SORTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define ISRT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ISRT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ISRT_ASSERT_NOW(label, ante, cons)
`define ISRT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hw/rtl/ins_sort_pkg.sv
// Shared types and constants for the insertion sorter.
// Used by ins_sort_cell and insertion_sorter_top; depends on nothing else.
`timescale 1ns / 1ps

package ins_sort_pkg;

   // Number of cells in the chain, which is the capacity of one set.
   localparam int MAX_ITEMS = 32;

   typedef logic signed [31:0] value_type;

   // Status that each cell shows to its neighbors.
   typedef struct packed {
      value_type value;
      logic      occupied;
      logic      greater;
   } cell_stat_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic      insert;
      logic      shift_left;
      value_type new_value;
   } cell_ctrl_type;

   // Virtual neighbor left of the first cell: occupied and never greater.
   localparam cell_stat_type CELL_HEAD = '{value: '0, occupied: 1'b1, greater: 1'b0};

   // Virtual neighbor right of the last cell: always empty.
   localparam cell_stat_type CELL_TAIL = '{value: '0, occupied: 1'b0, greater: 1'b0};

endpackage

>>> hw/rtl/ins_sort_cell.sv
// One cell of the systolic insertion chain: holds one sorted entry.
// Depends on ins_sort_pkg for the cell status and command types.
`timescale 1ns / 1ps

module ins_sort_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  ins_sort_pkg::cell_ctrl_type ctrl,
   input  ins_sort_pkg::cell_stat_type left_stat,
   input  ins_sort_pkg::cell_stat_type right_stat,
   output ins_sort_pkg::cell_stat_type own_stat
);
   import ins_sort_pkg::*;

   value_type value_ff;
   value_type value_in;
   logic      occupied_ff;
   logic      occupied_in;
   logic      greater;

   // A stored entry strictly above the new value moves right; equal entries stay ahead.
   assign greater = occupied_ff && (value_ff > ctrl.new_value);

   // Next entry: shift right on insert, take the new value at the insert point,
   // or shift left while the set is drained.
   always_comb begin
      value_in    = value_ff;
      occupied_in = occupied_ff;
      if (ctrl.shift_left) begin
         value_in    = right_stat.value;
         occupied_in = right_stat.occupied;
      end else if (ctrl.insert) begin
         if (left_stat.greater) begin
            value_in    = left_stat.value;
            occupied_in = 1'b1;
         end else if ((greater || !occupied_ff) && left_stat.occupied) begin
            value_in    = ctrl.new_value;
            occupied_in = 1'b1;
         end
      end
   end

   // The occupied bit is control state; the entry itself needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff <= 1'b0;
      end else begin
         occupied_ff <= occupied_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign own_stat = '{value: value_ff, occupied: occupied_ff, greater: greater};

endmodule

>>> hw/rtl/insertion_sorter_top.sv
// Stable ascending insertion sorter for signed 32-bit values, built as a chain
// of MAX_ITEMS cells. While a set is filling, one item is taken every cycle and
// inserted into the chain in that cycle. The transfer that carries last starts
// the drain: the input is stalled and the set leaves through a result register
// at one result per cycle from cell 0 while the result side does not stall.
// Items that arrive while the chain is full are dropped and mark every result
// of that set with overflow. Depends on ins_sort_pkg, ins_sort_cell and the
// assertion macro header.
`timescale 1ns / 1ps
`include "insertion_sorter_top_defines.svh"

module insertion_sorter_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ins_sort_pkg::value_type req_value,
   input  logic                    req_last,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ins_sort_pkg::value_type rsp_sorted_value,
   output logic                    rsp_last_out,
   output logic                    rsp_overflow
);
   import ins_sort_pkg::*;

   cell_stat_type              cell_stat [MAX_ITEMS];
   cell_ctrl_type              ctrl;
   logic [MAX_ITEMS-1:0]       occ_vec;
   logic                       req_xfer;
   logic                       full;
   logic                       emit;
   logic                       emit_last;

   logic                       drain_ff;
   logic                       drain_in;
   logic                       dropped_ff;
   logic                       dropped_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   value_type                  rsp_value_ff;
   logic                       rsp_last_ff;
   logic                       rsp_overflow_ff;

   // Chain of cells, each linked to both neighbors.
   genvar gi;
   generate
      for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
         cell_stat_type left_stat;
         cell_stat_type right_stat;
         if (gi == 0) begin : g_head
            assign left_stat = CELL_HEAD;
         end else begin : g_body
            assign left_stat = cell_stat[gi-1];
         end
         if (gi == MAX_ITEMS - 1) begin : g_tail
            assign right_stat = CELL_TAIL;
         end else begin : g_mid
            assign right_stat = cell_stat[gi+1];
         end
         ins_sort_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .left_stat  (left_stat),
            .right_stat (right_stat),
            .own_stat   (cell_stat[gi])
         );
         assign occ_vec[gi] = cell_stat[gi].occupied;
      end
   endgenerate

   // Handshake decode and the command broadcast to the chain.
   assign req_xfer  = req_valid && !drain_ff;
   assign full      = occ_vec[MAX_ITEMS-1];
   assign emit      = drain_ff && (!rsp_valid_ff || !rsp_stall);
   assign emit_last = emit && !cell_stat[1].occupied;

   assign ctrl = '{insert: req_xfer && !full, shift_left: emit, new_value: req_value};

   // Next state of the drain and overflow control and the result valid.
   always_comb begin
      drain_in   = drain_ff;
      dropped_in = dropped_ff;
      if (req_xfer && req_last) begin
         drain_in = 1'b1;
      end else if (emit_last) begin
         drain_in = 1'b0;
      end
      if (req_xfer && full) begin
         dropped_in = 1'b1;
      end else if (emit_last) begin
         dropped_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff     <= 1'b0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         drain_ff     <= drain_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result register, loaded from the head cell on every emitted transfer.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_value_ff    <= cell_stat[0].value;
         rsp_last_ff     <= emit_last;
         rsp_overflow_ff <= dropped_ff;
      end
   end

   assign req_stall        = drain_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_overflow     = rsp_overflow_ff;

   // Checks on the chain and the drain control.
   `ISRT_ASSERT_NOW(a_drain_has_entry, drain_ff, occ_vec[0])
   `ISRT_ASSERT_NOW(a_occ_prefix, !occ_vec[0], $countones(occ_vec) == 0)
   `ISRT_ASSERT_NEXT(a_last_starts_drain, req_xfer && req_last, drain_ff)
   `ISRT_ASSERT_NEXT(a_last_ends_drain, emit_last, !drain_ff && !dropped_ff && !occ_vec[0])

endmodule
